// ===== rtl/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
// used by the front decoder, the descriptor queue, the back sequencer and the top level
package u8u16_pkg;

  // status codes of a result transaction
  localparam logic [1:0] ST_UNIT      = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_END_EMPTY = 2'd3;

  // descriptor queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_string;
    logic       end_of_string;
  } u8u16_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        string_done;
    logic        last_of_run;
  } u8u16_out_t;

  // results caused by one byte, handed from front to back
  typedef struct packed {
    logic        two;      // a second result (low surrogate) follows
    logic [15:0] unit0;
    logic [1:0]  status0;
    logic [15:0] unit1;
    logic        done;     // byte carried end of string
  } u8u16_desc_t;

endpackage

// ===== rtl/u8u16_front.sv =====
// front decoder: holds the utf-8 decode state and turns each byte into a result descriptor
// depends on u8u16_pkg
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  u8u16_in_t   in_data,
  input  logic        accept,
  output logic        push,
  output u8u16_desc_t desc
);

  logic [20:0] pcp_r, pcp_nxt;
  logic [1:0]  owed_r, owed_nxt;
  logic [1:0]  len_r, len_nxt;
  logic        halt_r, halt_nxt;

  logic [20:0] pcp_c;
  logic [1:0]  owed_c;
  logic [1:0]  len_c;
  logic        halt_c;
  logic [7:0]  c;
  logic        complete;
  logic        bad;
  logic [1:0]  n;
  logic [20:0] u;
  logic [20:0] v;

  // decode one byte
  always_comb begin
    c        = in_data.data_byte;
    pcp_c    = in_data.start_of_string ? 21'd0 : pcp_r;
    owed_c   = in_data.start_of_string ? 2'd0 : owed_r;
    len_c    = in_data.start_of_string ? 2'd0 : len_r;
    halt_c   = in_data.start_of_string ? 1'b0 : halt_r;
    pcp_nxt  = pcp_c;
    owed_nxt = owed_c;
    len_nxt  = len_c;
    halt_nxt = halt_c;
    complete = 1'b0;
    bad      = 1'b0;
    n        = 2'd0;
    desc     = '0;

    if (!halt_c) begin
      if (owed_c == 2'd0) begin
        // lead byte classification
        unique casez (c)
          8'b0???????: begin
            pcp_nxt  = {13'd0, c};
            len_nxt  = 2'd0;
            complete = 1'b1;
          end
          8'b110?????: begin
            pcp_nxt  = {16'd0, c[4:0]};
            owed_nxt = 2'd1;
            len_nxt  = 2'd1;
          end
          8'b1110????: begin
            pcp_nxt  = {17'd0, c[3:0]};
            owed_nxt = 2'd2;
            len_nxt  = 2'd2;
          end
          8'b11110???: begin
            pcp_nxt  = {18'd0, c[2:0]};
            owed_nxt = 2'd3;
            len_nxt  = 2'd3;
          end
          default: bad = 1'b1;
        endcase
      end else if (c[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        pcp_nxt  = {pcp_c[14:0], c[5:0]};
        owed_nxt = owed_c - 2'd1;
        complete = (owed_c == 2'd1);
      end
    end

    u = pcp_nxt;
    v = u - 21'h10000;

    // finished code point: range and overlong checks
    if (complete) begin
      if ((u <= 21'h7f && len_nxt != 2'd0) ||
          (u > 21'h7f && u <= 21'h7ff && len_nxt != 2'd1) ||
          (u > 21'h7ff && u <= 21'hffff && len_nxt != 2'd2) ||
          (u >= 21'hd800 && u <= 21'hdfff)) begin
        bad = 1'b1;
      end else if (u < 21'h10000) begin
        n            = 2'd1;
        desc.unit0   = u[15:0];
        desc.status0 = ST_UNIT;
      end else if (u <= 21'h10ffff) begin
        n            = 2'd2;
        desc.two     = 1'b1;
        desc.unit0   = 16'hd800 | {6'd0, v[19:10]};
        desc.status0 = ST_UNIT;
        desc.unit1   = 16'hdc00 | {6'd0, v[9:0]};
      end
      pcp_nxt = 21'd0;
      len_nxt = 2'd0;
    end

    // malformed sequence halts until the next start or end of string
    if (bad) begin
      pcp_nxt      = 21'd0;
      owed_nxt     = 2'd0;
      len_nxt      = 2'd0;
      halt_nxt     = 1'b1;
      n            = 2'd1;
      desc.two     = 1'b0;
      desc.unit0   = 16'd0;
      desc.status0 = ST_MALFORMED;
    end

    // end of string: report when nothing else came out, then clear
    if (in_data.end_of_string) begin
      if (n == 2'd0) begin
        n            = 2'd1;
        desc.unit0   = 16'd0;
        desc.status0 = (!halt_nxt && owed_nxt != 2'd0) ? ST_TRUNCATED : ST_END_EMPTY;
      end
      desc.done = 1'b1;
      pcp_nxt   = 21'd0;
      owed_nxt  = 2'd0;
      len_nxt   = 2'd0;
      halt_nxt  = 1'b0;
    end

    push = accept && (n != 2'd0);
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcp_r  <= '0;
      owed_r <= '0;
      len_r  <= '0;
      halt_r <= 1'b0;
    end else if (accept) begin
      pcp_r  <= pcp_nxt;
      owed_r <= owed_nxt;
      len_r  <= len_nxt;
      halt_r <= halt_nxt;
    end
  end

  // a halted decoder holds no partial sequence
  a_halt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (owed_r == 2'd0 && pcp_r == 21'd0))
    else $error("halted decoder holds a partial sequence");

  // with nothing owed there is no sequence in progress
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (owed_r == 2'd0) |-> (len_r == 2'd0 && pcp_r == 21'd0))
    else $error("decoder idle but sequence state not clear");

endmodule

// ===== rtl/u8u16_queue.sv =====
// small descriptor queue between the front decoder and the back sequencer
// depends on u8u16_pkg
module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  u8u16_desc_t push_data,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output u8u16_desc_t head
);

  u8u16_desc_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r;
  logic [QPTR_W-1:0]   rd_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // no push into a full queue unless a pop frees a slot, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop) && !(pop && !not_empty))
    else $error("descriptor queue overflow or underflow");

endmodule

// ===== rtl/u8u16_back.sv =====
// back sequencer: emits the one or two results of the head descriptor
// depends on u8u16_pkg
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  u8u16_desc_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output u8u16_out_t  out_data
);

  logic sel_r;
  logic last;

  // pick the current result of the run
  always_comb begin
    last      = sel_r || !head.two;
    out_valid = head_valid;
    out_data.code_unit   = sel_r ? head.unit1 : head.unit0;
    out_data.status      = sel_r ? ST_UNIT : head.status0;
    out_data.string_done = last && head.done;
    out_data.last_of_run = last;
    pop = head_valid && !out_stall && last;
  end

  // second-result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (head_valid && !out_stall) begin
      sel_r <= !last;
    end
  end

  // the second result is only ever shown for a pair descriptor
  a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (head_valid && head.two))
    else $error("second result selected without a pair at the head");

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// utf-8 to utf-16 transcoder: one byte per transaction in, one code unit per transaction out
// a byte's results are written into the registered descriptor queue and offered from its head
// throughput: one byte per cycle unless the queue is full; one result per cycle out unless
// stalled; a surrogate pair gives two results and a four-entry queue absorbs the difference
// reset: synchronous active-low rst_n clears decoder state, queue pointers and sequencer
// depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  u8u16_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output u8u16_out_t out_data
);

  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        not_empty;
  u8u16_desc_t desc;
  u8u16_desc_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  u8u16_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (accept),
    .push    (push),
    .desc    (desc)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (desc),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== bench/utf8_to_utf16_transcoder_test.sv =====
// self-checking testbench for utf8_to_utf16_transcoder: directed and random utf-8 strings,
// bursty sender, patterned receiver stalls, in-bench decoder predicts every utf-16 transaction
// depends on u8u16_pkg and the transcoder rtl
module utf8_to_utf16_transcoder_test;
  import u8u16_pkg::*;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  // byte transaction waiting to be sent; drain holds it until all results are in
  typedef struct packed {
    logic      drain;
    u8u16_in_t item;
  } byte_txn_t;

  // directed strings, each entry is {data_byte, start_of_string, end_of_string}
  localparam logic [9:0] DIRECTED_SEQ [0:25] = '{
    // nul, ascii top, two-byte top
    {8'h00, 2'b10}, {8'h7f, 2'b00}, {8'hdf, 2'b00}, {8'hbf, 2'b01},
    // three-byte top, then largest code point as a surrogate pair
    {8'hef, 2'b10}, {8'hbf, 2'b00}, {8'hbf, 2'b00},
    {8'hf4, 2'b00}, {8'h8f, 2'b00}, {8'hbf, 2'b00}, {8'hbf, 2'b01},
    // code point past 0x10ffff is dropped, end reported without a unit
    {8'hf4, 2'b10}, {8'h90, 2'b00}, {8'h80, 2'b00}, {8'h80, 2'b01},
    // encoded surrogate, then a byte ignored while halted
    {8'hed, 2'b10}, {8'ha0, 2'b00}, {8'h80, 2'b00}, {8'h41, 2'b01},
    // overlong nul, then 0xff ignored while halted
    {8'hc0, 2'b10}, {8'h80, 2'b00}, {8'hff, 2'b01},
    // bad continuation, restart clears the halt, sequence cut off by the end
    {8'hc3, 2'b10}, {8'h41, 2'b00}, {8'he2, 2'b10}, {8'h82, 2'b01}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  u8u16_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  u8u16_out_t out_data;

  byte_txn_t  feed_q[$];
  u8u16_out_t units_q[$];
  logic [7:0] str_q[$];
  byte_txn_t  next_txn;

  // decoder state of the predictor
  logic [20:0] dec_cp = '0;
  logic [1:0]  dec_owed = '0;
  logic [1:0]  dec_len = '0;
  logic        dec_halted = 1'b0;

  int total_items;
  int sent_cnt;
  int err_cnt;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;
  int stall_phase;

  utf8_to_utf16_transcoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic clear_decoder();
    dec_cp     = '0;
    dec_owed   = '0;
    dec_len    = '0;
    dec_halted = 1'b0;
  endtask

  // decode one accepted byte and queue the utf-16 transactions it causes
  task automatic predict_units(input u8u16_in_t b);
    logic [7:0]  c;
    logic [20:0] off;
    logic        complete;
    logic        bad;
    u8u16_out_t  res [0:1];
    int          n;
    c        = b.data_byte;
    complete = 1'b0;
    bad      = 1'b0;
    n        = 0;
    res[0]   = '0;
    res[1]   = '0;
    if (b.start_of_string) clear_decoder();

    if (!dec_halted) begin
      // lead byte or continuation byte
      if (dec_owed == 2'd0) begin
        if (c[7] == 1'b0) begin
          dec_cp   = {13'd0, c};
          dec_len  = 2'd0;
          complete = 1'b1;
        end else if (c[7:5] == 3'b110) begin
          dec_cp   = {16'd0, c[4:0]};
          dec_owed = 2'd1;
          dec_len  = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
          dec_cp   = {17'd0, c[3:0]};
          dec_owed = 2'd2;
          dec_len  = 2'd2;
        end else if (c[7:3] == 5'b11110) begin
          dec_cp   = {18'd0, c[2:0]};
          dec_owed = 2'd3;
          dec_len  = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (c[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        dec_cp   = {dec_cp[14:0], c[5:0]};
        dec_owed = dec_owed - 2'd1;
        if (dec_owed == 2'd0) complete = 1'b1;
      end

      // finished code point: overlong and surrogate checks, then one or two units, or none past 0x10ffff
      if (complete) begin
        if ((dec_cp <= 21'h7f && dec_len != 2'd0) ||
            (dec_cp > 21'h7f && dec_cp <= 21'h7ff && dec_len != 2'd1) ||
            (dec_cp > 21'h7ff && dec_cp <= 21'hffff && dec_len != 2'd2) ||
            (dec_cp >= 21'hd800 && dec_cp <= 21'hdfff)) begin
          bad = 1'b1;
        end else if (dec_cp < 21'h10000) begin
          res[n].code_unit = dec_cp[15:0];
          res[n].status    = ST_UNIT;
          n++;
        end else if (dec_cp <= 21'h10ffff) begin
          off = dec_cp - 21'h10000;
          res[n].code_unit = {6'b110110, off[19:10]};
          res[n].status    = ST_UNIT;
          n++;
          res[n].code_unit = {6'b110111, off[9:0]};
          res[n].status    = ST_UNIT;
          n++;
        end
        dec_cp  = '0;
        dec_len = '0;
      end

      if (bad) begin
        dec_cp     = '0;
        dec_owed   = '0;
        dec_len    = '0;
        dec_halted = 1'b1;
        res[n].status = ST_MALFORMED;
        n++;
      end
    end

    // end of string: truncation or empty end marker, then a fresh decoder
    if (b.end_of_string) begin
      if (n == 0) begin
        res[0].status = (!dec_halted && dec_owed != 2'd0) ? ST_TRUNCATED : ST_END_EMPTY;
        n = 1;
      end
      res[n-1].string_done = 1'b1;
      clear_decoder();
    end

    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) units_q.push_back(res[k]);
  endtask

  // utf-8 encoding of cp in nb bytes, longer than needed gives an overlong form
  task automatic encode_cp(input logic [20:0] cp, input int nb);
    case (nb)
      1: str_q.push_back({1'b0, cp[6:0]});
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // well-formed character, range edges now and then
  task automatic pick_char(output logic [20:0] cp, output int nb);
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      nb = 1; lo = 'h0; hi = 'h7f;
    end else if (r < 50) begin
      nb = 2; lo = 'h80; hi = 'h7ff;
    end else if (r < 72) begin
      nb = 3; lo = 'h800; hi = 'hffff;
    end else begin
      nb = 4; lo = 'h10000; hi = 'h10ffff;
    end
    if ($urandom_range(0, 9) == 0) begin
      cp = 21'($urandom_range(0, 1) ? hi : lo);
    end else begin
      cp = 21'($urandom_range(lo, hi));
    end
    // move surrogates out of the way
    if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
  endtask

  // hand the built string to the sender with random framing flags
  task automatic queue_string(input logic hold);
    byte_txn_t t;
    for (int i = 0; i < str_q.size(); i++) begin
      t = '0;
      t.item.data_byte = str_q[i];
      if (i == 0) t.item.start_of_string = ($urandom_range(0, 9) != 0);
      else        t.item.start_of_string = ($urandom_range(0, 49) == 0);
      t.item.end_of_string = (i == str_q.size() - 1) && ($urandom_range(0, 9) != 0);
      t.drain = hold && (i == 0);
      feed_q.push_back(t);
    end
  endtask

  // mostly well-formed strings, some with one fault, a few pure noise
  task automatic build_random();
    int          nchars;
    int          fault_at;
    int          fault_kind;
    int          nb;
    int          drop;
    logic [20:0] cp;
    logic        hold;
    hold = 1'b1;
    while (feed_q.size() < $size(DIRECTED_SEQ) + RANDOM_ITEMS) begin
      str_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        nchars     = $urandom_range(1, 12);
        fault_kind = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 5) : -1;
        fault_at   = $urandom_range(0, nchars - 1);
        for (int k = 0; k < nchars; k++) begin
          if (k == fault_at) begin
            case (fault_kind)
              0: begin
                // overlong form
                nb = $urandom_range(2, 4);
                case (nb)
                  2:       encode_cp(21'($urandom_range(0, 'h7f)), 2);
                  3:       encode_cp(21'($urandom_range(0, 'h7ff)), 3);
                  default: encode_cp(21'($urandom_range(0, 'hffff)), 4);
                endcase
              end
              1: encode_cp(21'($urandom_range('hd800, 'hdfff)), 3);
              2: encode_cp(21'($urandom_range('h110000, 'h1fffff)), 4);
              3: str_q.push_back(8'($urandom_range(128, 255)));
              5: begin
                // multi-byte sequence whose last byte is replaced by a non-continuation byte
                encode_cp(21'($urandom_range('h80, 'h10ffff)), $urandom_range(2, 4));
                void'(str_q.pop_back());
                str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                     : 8'($urandom_range(192, 255)));
              end
              default: ;
            endcase
          end
          pick_char(cp, nb);
          encode_cp(cp, nb);
        end
        // sequence cut short at the tail
        if (fault_kind == 4) begin
          nb = $urandom_range(2, 4);
          encode_cp(21'($urandom_range('h800, 'h10ffff)), nb);
          drop = $urandom_range(1, nb - 1);
          repeat (drop) void'(str_q.pop_back());
        end
      end
      queue_string(hold);
      hold = ($urandom_range(0, 39) == 0);
    end
  endtask

  // stimulus build, reset, end of run
  initial begin
    byte_txn_t t;
    for (int i = 0; i < $size(DIRECTED_SEQ); i++) begin
      t      = '0;
      t.item = DIRECTED_SEQ[i];
      feed_q.push_back(t);
    end
    build_random();
    total_items = feed_q.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt != total_items) @(posedge clk);
    while (units_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && units_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver: bursts of byte transactions with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_units(in_data);
        sent_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (feed_q.size() != 0 && !(feed_q[0].drain && units_q.size() != 0)) begin
          next_txn = feed_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_txn.item;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 9) == 0) begin
              burst_left = 200;
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 48);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result transaction, then pick the next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (units_q.size() == 0) begin
          note_mismatch($sformatf("unexpected unit %h status %0d done %b last %b",
                                  out_data.code_unit, out_data.status,
                                  out_data.string_done, out_data.last_of_run));
        end else begin
          if (out_data !== units_q[0]) begin
            note_mismatch($sformatf(
              "exp unit %h status %0d done %b last %b, got unit %h status %0d done %b last %b",
              units_q[0].code_unit, units_q[0].status, units_q[0].string_done,
              units_q[0].last_of_run, out_data.code_unit, out_data.status,
              out_data.string_done, out_data.last_of_run));
          end
          void'(units_q.pop_front());
        end
      end

      // stall pattern switches between randomly picked modes
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      stall_phase++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        3:       out_stall <= (stall_phase % 2 == 0);
        default: out_stall <= (stall_phase % 5 < 3);
      endcase
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== utf8_to_utf16_transcoder.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
bench/utf8_to_utf16_transcoder_test.sv
